### hw/rtl/svf_pkg.sv
package svf_pkg;

  // field and datapath widths
  localparam int SAMPLE_W = 16;
  localparam int STATE_W  = 24;
  localparam int COEFF_W  = 16;
  localparam int FRAC_W   = 14;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 2;

  // product of an unsigned coefficient and a signed state value
  localparam int PROD_W = COEFF_W + 1 + STATE_W;
  // product after the rounding shift
  localparam int SCL_W  = PROD_W - FRAC_W;
  // addend: state value or sample minus lowpass state
  localparam int ADD_W  = STATE_W + 2;
  // sum of addend and scaled product
  localparam int SUM_W  = ((SCL_W > ADD_W) ? SCL_W : ADD_W) + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

  // output selection codes, anything else is highpass
  localparam logic [MODE_W-1:0] MODE_LOW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BAND = 2'd1;

  // damping coefficient after reset: 2.0 in Q2.14
  localparam logic [COEFF_W-1:0] DAMP_RESET = COEFF_W'(1) << (FRAC_W + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIGH,
    ST_BAND,
    ST_LOW
  } svf_state_t;

  // sequencer controls toward the datapath
  typedef struct packed {
    logic in_ready;
    logic ld_high;
    logic ld_band;
    logic ld_low;
  } svf_ctl_t;

  // clamp a wide sum to the state width
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-STATE_W:0] top;
    top = v[SUM_W-1:STATE_W-1];
    if ((&top) || (~|top)) begin
      sat_state = v[STATE_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat_state = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      sat_state = {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

  // clamp a state value to the sample width
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [STATE_W-1:0] v
  );
    logic [STATE_W-SAMPLE_W:0] top;
    top = v[STATE_W-1:SAMPLE_W-1];
    if ((&top) || (~|top)) begin
      sat_sample = v[SAMPLE_W-1:0];
    end else if (v[STATE_W-1]) begin
      sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

### hw/rtl/svf_mac.sv
module svf_mac (
  input  logic [svf_pkg::COEFF_W-1:0]        coeff,
  input  logic signed [svf_pkg::STATE_W-1:0] sig,
  input  logic signed [svf_pkg::ADD_W-1:0]   addend,
  input  logic                               sub,
  output logic signed [svf_pkg::STATE_W-1:0] result
);

  logic signed [svf_pkg::COEFF_W:0]   coeff_s;
  logic signed [svf_pkg::PROD_W-1:0]  prod;
  logic signed [svf_pkg::PROD_W-1:0]  prod_rnd;
  logic signed [svf_pkg::SCL_W-1:0]   scaled;
  logic signed [svf_pkg::SUM_W-1:0]   sum;

  // exact product, coefficient taken as unsigned
  assign coeff_s = {1'b0, coeff};
  assign prod    = svf_pkg::PROD_W'(coeff_s) * svf_pkg::PROD_W'(sig);

  // round half up, then floor shift out the fraction
  assign prod_rnd = prod + (svf_pkg::PROD_W'(1) <<< (svf_pkg::FRAC_W - 1));
  assign scaled   = prod_rnd[svf_pkg::PROD_W-1:svf_pkg::FRAC_W];

  // accumulate and clamp to the state range
  always_comb begin
    if (sub) begin
      sum = svf_pkg::SUM_W'(addend) - svf_pkg::SUM_W'(scaled);
    end else begin
      sum = svf_pkg::SUM_W'(addend) + svf_pkg::SUM_W'(scaled);
    end
  end

  assign result = svf_pkg::sat_state(sum);

endmodule

### hw/rtl/svf_ctrl.sv
module svf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_free,
  output svf_pkg::svf_ctl_t ctl
);

  svf_pkg::svf_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state: accept, then highpass, bandpass and lowpass updates
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      svf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = svf_pkg::ST_HIGH;
      end
      svf_pkg::ST_HIGH: state_nxt = svf_pkg::ST_BAND;
      svf_pkg::ST_BAND: state_nxt = svf_pkg::ST_LOW;
      // last update waits for the output register
      svf_pkg::ST_LOW: begin
        if (out_free) state_nxt = svf_pkg::ST_IDLE;
      end
      default:          state_nxt = svf_pkg::ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    ctl = '0;
    case (state_r)
      svf_pkg::ST_IDLE: ctl.in_ready = 1'b1;
      svf_pkg::ST_HIGH: ctl.ld_high  = 1'b1;
      svf_pkg::ST_BAND: ctl.ld_band  = 1'b1;
      svf_pkg::ST_LOW:  ctl.ld_low   = out_free;
      default:          ctl = '0;
    endcase
  end

endmodule

### hw/rtl/state_variable_filter_unit.sv
// Chamberlin state-variable filter, one signed 16-bit sample per word. Each
// sample updates highpass = x - low - damping*band, band += freq*high and
// low += freq*band, all through one shared multiply-round-accumulate unit
// with saturation to 24 bits; the low, band or high value chosen by
// output_mode (3 acts as highpass) comes out saturated to 16 bits. Each
// sample is accepted and then makes three passes through the shared
// multiplier, one for each product, which depend on each other. The result
// sits in an output register, so a new sample is taken while the last
// result is still waiting; the final update of the new sample holds until
// that register is empty or being read. Coefficients are Q2.14 (freq
// 2*sin(pi*fc/fs), damping twice the attenuation, 2.0 after reset); write
// them only while no sample is in flight. The configuration port is always
// ready.
module state_variable_filter_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [svf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [svf_pkg::COEFF_W-1:0]          cfg_data,
  // sample input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [svf_pkg::SAMPLE_W-1:0]  in_sample,
  // filtered output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [svf_pkg::SAMPLE_W-1:0]  out_filtered_sample
);

  svf_pkg::svf_ctl_t ctl;

  logic [svf_pkg::COEFF_W-1:0]         freq_r;
  logic [svf_pkg::COEFF_W-1:0]         damp_r;
  logic [svf_pkg::MODE_W-1:0]          mode_r;
  logic signed [svf_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [svf_pkg::STATE_W-1:0]  high_r;
  logic signed [svf_pkg::STATE_W-1:0]  band_r;
  logic signed [svf_pkg::STATE_W-1:0]  low_r;
  logic                                out_valid_r;
  logic signed [svf_pkg::SAMPLE_W-1:0] out_data_r;

  logic                                out_free;
  logic [svf_pkg::COEFF_W-1:0]         mac_coeff;
  logic signed [svf_pkg::STATE_W-1:0]  mac_sig;
  logic signed [svf_pkg::ADD_W-1:0]    mac_addend;
  logic                                mac_sub;
  logic signed [svf_pkg::STATE_W-1:0]  mac_result;
  logic signed [svf_pkg::STATE_W-1:0]  out_sel;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= '0;
      damp_r <= svf_pkg::DAMP_RESET;
      mode_r <= svf_pkg::MODE_LOW;
    end else if (cfg_valid) begin
      case (cfg_index)
        svf_pkg::CFG_FREQ: freq_r <= cfg_data;
        svf_pkg::CFG_DAMP: damp_r <= cfg_data;
        svf_pkg::CFG_MODE: mode_r <= cfg_data[svf_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // output register is free once empty or being taken this cycle
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = ctl.in_ready;

  svf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // operand selection for the shared unit
  always_comb begin
    mac_coeff  = freq_r;
    mac_sig    = band_r;
    mac_addend = svf_pkg::ADD_W'(low_r);
    mac_sub    = 1'b0;
    if (ctl.ld_high) begin
      mac_coeff  = damp_r;
      mac_sig    = band_r;
      mac_addend = svf_pkg::ADD_W'(sample_r) - svf_pkg::ADD_W'(low_r);
      mac_sub    = 1'b1;
    end else if (ctl.ld_band) begin
      mac_coeff  = freq_r;
      mac_sig    = high_r;
      mac_addend = svf_pkg::ADD_W'(band_r);
      mac_sub    = 1'b0;
    end
  end

  svf_mac u_mac (
    .coeff  (mac_coeff),
    .sig    (mac_sig),
    .addend (mac_addend),
    .sub    (mac_sub),
    .result (mac_result)
  );

  // sample capture and highpass value
  always_ff @(posedge clk) begin
    if (in_valid && ctl.in_ready) sample_r <= in_sample;
    if (ctl.ld_high) high_r <= mac_result;
  end

  // integrator states
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= '0;
      low_r  <= '0;
    end else begin
      if (ctl.ld_band) band_r <= mac_result;
      if (ctl.ld_low)  low_r  <= mac_result;
    end
  end

  // output selection, lowpass comes straight from the unit
  always_comb begin
    case (mode_r)
      svf_pkg::MODE_LOW:  out_sel = mac_result;
      svf_pkg::MODE_BAND: out_sel = band_r;
      default:            out_sel = high_r;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.ld_low) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_low) out_data_r <= svf_pkg::sat_sample(out_sel);
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_data_r;

endmodule
